>>> hdl/mav_pkg.sv
// Shared types, constants and codes for the MJPEG to AVI remuxer.
// No dependencies; every other file but mav_ram refers to it by scoped names.
`timescale 1ns / 1ps
package mav_pkg;

  localparam int MAX_INDEXED_FRAMES = 16384;
  localparam int HEADER_LEN         = 92;
  localparam int SIZE_POS           = 78;
  localparam int SIZE_CHARS         = 10;

  localparam int FRAME_AW = (MAX_INDEXED_FRAMES > 1) ? $clog2(MAX_INDEXED_FRAMES) : 1;
  localparam int REC_W    = $clog2(MAX_INDEXED_FRAMES + 1);
  localparam int HPOS_W   = $clog2(HEADER_LEN);
  localparam int PTR_W    = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_SIZE  = 1'b1;

  localparam logic [1:0] KIND_VIDEO = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_REQ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [3:0] LAST_ONE   = 4'd0;
  localparam logic [3:0] LAST_CHUNK = 4'd7;
  localparam logic [3:0] LAST_ENTRY = 4'd15;

  // Tags packed so that the first stream byte sits in bits 7:0.
  localparam logic [31:0] TAG_VIDEO = 32'h6364_3030;
  localparam logic [31:0] TAG_AUDIO = 32'h6277_3130;
  localparam logic [31:0] TAG_INDEX = 32'h3178_6469;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_INDEX,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    PS_SKIP,
    PS_POS,
    PS_NEG,
    PS_DONE
  } parse_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       index_finished;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [3:0]  last_idx;
    logic [1:0]  status;
    logic        fin;
  } burst_t;

  typedef struct packed {
    logic   push;
    logic   fill;
    burst_t burst;
  } ctl_t;

endpackage

>>> hdl/mjpeg_to_avi_remuxer.sv
// Top level of the MJPEG to AVI remuxer: movie chunks and idx1 index.
// Instantiates mav_core, mav_emit and mav_ram; depends on mav_pkg.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_ready  mav_pkg::in_t  (kind, data_byte)
//   out_*        output     out_valid/out_ready  mav_pkg::out_t (byte, flags, status)
//   cfg_*        input      cfg_we               cfg_index, cfg_wdata (32 bit)
//
// Payload bytes pass one request per cycle while out_ready holds; out_valid is registered.
// Header bytes are taken one per cycle while no burst pends; the last one queues an 8-byte
// chunk header, or a one-byte stop result if the size is zero. A burst may be followed by
// one more in the single pending slot; bytes leave one per cycle while out_ready holds.
// An index entry request also stalls input until the frame size store read is patched in.
// Reset is synchronous; the size store is not cleared, entries are used only once written.
`timescale 1ns / 1ps
module mjpeg_to_avi_remuxer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mav_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mav_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mav_pkg::out_t                 out_data
);

  mav_pkg::ctl_t                  ctl;
  logic                           pend_full;
  logic [31:0]                    rd_data;
  logic                           mem_we;
  logic [mav_pkg::FRAME_AW-1:0]   mem_waddr;
  logic [31:0]                    mem_wdata;
  logic [mav_pkg::FRAME_AW-1:0]   mem_raddr;

  mav_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .pend_full (pend_full),
    .rd_data   (rd_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .ctl       (ctl)
  );

  mav_ram #(
    .WIDTH (32),
    .DEPTH (mav_pkg::MAX_INDEXED_FRAMES)
  ) u_size_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  mav_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .fill_data (rd_data),
    .pend_full (pend_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hdl/mav_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module mav_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mav_core.sv
// Request decoder: header parse, frame size store control, index sequencing.
// Issues byte bursts to mav_emit; depends on mav_pkg.
`timescale 1ns / 1ps
module mav_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mav_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mav_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  input  mav_pkg::in_t                       in_data,
  output logic                               in_ready,
  input  logic                               pend_full,
  input  logic [31:0]                        rd_data,
  output logic                               mem_we,
  output logic [mav_pkg::FRAME_AW-1:0]       mem_waddr,
  output logic [31:0]                        mem_wdata,
  output logic [mav_pkg::FRAME_AW-1:0]       mem_raddr,
  output mav_pkg::ctl_t                      ctl
);

  mav_pkg::phase_t                   phase_r, phase_nxt;
  mav_pkg::parse_t                   ps_r, ps_nxt, ps_p;
  logic [mav_pkg::HPOS_W-1:0]        hpos_r, hpos_nxt;
  logic [31:0]                       acc_r, acc_nxt, acc_p;
  logic [31:0]                       left_r, left_nxt;
  logic [mav_pkg::REC_W-1:0]         nrec_r, nrec_nxt;
  logic [mav_pkg::PTR_W-1:0]         ptr_r, ptr_nxt;
  logic [31:0]                       offs_r, offs_nxt;
  logic                              aud_pend_r, aud_pend_nxt;
  logic [mav_pkg::FRAME_AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic [1:0]                        rd_wait_r, rd_wait_nxt;
  logic                              size_ok_r, size_ok_nxt;
  logic [15:0]                       fcnt_r;
  logic [31:0]                       aud_r;

  logic        fire;
  logic [7:0]  ch;
  logic [7:0]  hpos_ext;
  logic        in_field;
  logic        hdr_last;
  logic        is_digit;
  logic        is_ws;
  logic        do_acc;
  logic [35:0] acc10;
  logic [31:0] sz_p;
  logic [16:0] entries;
  logic        ptr_in_cap;
  logic        ptr_recorded;

  assign fire     = in_valid && in_ready;
  assign in_ready = !pend_full && (rd_wait_r == 2'd0);
  assign ch       = in_data.data_byte;
  assign hpos_ext = 8'(hpos_r);
  assign in_field = (hpos_ext >= 8'(mav_pkg::SIZE_POS)) &&
                    (hpos_ext < 8'(mav_pkg::SIZE_POS + mav_pkg::SIZE_CHARS));
  assign hdr_last = (hpos_r == mav_pkg::HPOS_W'(mav_pkg::HEADER_LEN - 1));
  assign is_digit = (ch >= mav_pkg::CH_ZERO) && (ch <= mav_pkg::CH_NINE);
  assign is_ws    = (ch == mav_pkg::CH_SPACE) ||
                    ((ch >= mav_pkg::CH_TAB) && (ch <= mav_pkg::CH_CR));
  assign acc10    = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, ch[3:0]};
  assign entries  = {1'b0, fcnt_r} + {16'd0, (aud_r != 32'd0)};
  assign ptr_in_cap   = {1'b0, ptr_r} < 17'(mav_pkg::MAX_INDEXED_FRAMES);
  assign ptr_recorded = ptr_r < mav_pkg::PTR_W'(nrec_r);

  always_comb begin
    ps_p   = ps_r;
    do_acc = 1'b0;
    if (in_field) begin
      case (ps_r)
        mav_pkg::PS_SKIP: begin
          if (is_ws) begin
            ps_p = ps_r;
          end else if (ch == mav_pkg::CH_PLUS) begin
            ps_p = mav_pkg::PS_POS;
          end else if (ch == mav_pkg::CH_MINUS) begin
            ps_p = mav_pkg::PS_NEG;
          end else if (!is_digit) begin
            ps_p = mav_pkg::PS_DONE;
          end else begin
            ps_p   = mav_pkg::PS_POS;
            do_acc = 1'b1;
          end
        end
        mav_pkg::PS_DONE: begin
          ps_p = ps_r;
        end
        default: begin
          if (!is_digit) begin
            ps_p = mav_pkg::PS_DONE;
          end else begin
            do_acc = 1'b1;
          end
        end
      endcase
    end
    acc_p = acc_r;
    if (do_acc) begin
      acc_p = (|acc10[35:32]) ? 32'hFFFF_FFFF : acc10[31:0];
    end
    sz_p = (ps_p == mav_pkg::PS_NEG) ? (~acc_p + 32'd1) : acc_p;
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      mav_pkg::PH_HEADER: begin
        if (fire && in_data.kind == mav_pkg::KIND_END) begin
          phase_nxt = mav_pkg::PH_INDEX;
        end else if (fire && in_data.kind == mav_pkg::KIND_VIDEO && hdr_last) begin
          phase_nxt = (sz_p == 32'd0) ? mav_pkg::PH_STOPPED : mav_pkg::PH_PAYLOAD;
        end
      end
      mav_pkg::PH_PAYLOAD: begin
        if (fire && in_data.kind == mav_pkg::KIND_END) begin
          phase_nxt = mav_pkg::PH_INDEX;
        end else if (fire && in_data.kind == mav_pkg::KIND_VIDEO && left_r == 32'd1) begin
          phase_nxt = mav_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_comb begin
    ps_nxt       = ps_r;
    hpos_nxt     = hpos_r;
    acc_nxt      = acc_r;
    left_nxt     = left_r;
    nrec_nxt     = nrec_r;
    ptr_nxt      = ptr_r;
    offs_nxt     = offs_r;
    aud_pend_nxt = aud_pend_r;
    rd_addr_nxt  = rd_addr_r;
    size_ok_nxt  = size_ok_r;
    rd_wait_nxt  = (rd_wait_r != 2'd0) ? rd_wait_r - 2'd1 : 2'd0;
    mem_we       = 1'b0;
    mem_waddr    = nrec_r[mav_pkg::FRAME_AW-1:0];
    mem_wdata    = sz_p;
    ctl          = '0;

    if (fire) begin
      case (phase_r)
        mav_pkg::PH_STOPPED: begin
          ctl.push           = 1'b1;
          ctl.burst.last_idx = mav_pkg::LAST_ONE;
          ctl.burst.status   = mav_pkg::ST_ZERO;
        end
        mav_pkg::PH_INDEX: begin
          if (in_data.kind == mav_pkg::KIND_REQ) begin
            if (aud_pend_r && aud_r != 32'd0) begin
              ctl.push           = 1'b1;
              ctl.burst.w0       = mav_pkg::TAG_AUDIO;
              ctl.burst.w2       = offs_r;
              ctl.burst.w3       = aud_r;
              ctl.burst.last_idx = mav_pkg::LAST_ENTRY;
              ctl.burst.status   = mav_pkg::ST_OK;
              ctl.burst.fin      = (fcnt_r == 16'd0);
              offs_nxt           = offs_r + aud_r + 32'd8;
              aud_pend_nxt       = 1'b0;
            end else begin
              aud_pend_nxt = 1'b0;
              if (ptr_r < fcnt_r) begin
                ctl.push           = 1'b1;
                ctl.burst.w0       = mav_pkg::TAG_VIDEO;
                ctl.burst.w2       = offs_r;
                ctl.burst.last_idx = mav_pkg::LAST_ENTRY;
                ctl.burst.status   = ptr_in_cap ? mav_pkg::ST_OK : mav_pkg::ST_FULL;
                ctl.burst.fin      = ((ptr_r + 16'd1) == fcnt_r);
                ptr_nxt            = ptr_r + 16'd1;
                rd_addr_nxt        = ptr_r[mav_pkg::FRAME_AW-1:0];
                size_ok_nxt        = ptr_in_cap && ptr_recorded;
                rd_wait_nxt        = 2'd2;
              end
            end
          end
        end
        default: begin
          if (in_data.kind == mav_pkg::KIND_END) begin
            ctl.push           = 1'b1;
            ctl.burst.w0       = mav_pkg::TAG_INDEX;
            ctl.burst.w1       = {11'd0, entries, 4'd0};
            ctl.burst.last_idx = mav_pkg::LAST_CHUNK;
            ctl.burst.status   = mav_pkg::ST_OK;
          end else if (in_data.kind == mav_pkg::KIND_VIDEO) begin
            if (phase_r == mav_pkg::PH_PAYLOAD) begin
              ctl.push           = 1'b1;
              ctl.burst.w0       = {24'd0, ch};
              ctl.burst.last_idx = mav_pkg::LAST_ONE;
              ctl.burst.status   = mav_pkg::ST_OK;
              left_nxt           = left_r - 32'd1;
              if (left_r == 32'd1) begin
                hpos_nxt = '0;
                acc_nxt  = 32'd0;
                ps_nxt   = mav_pkg::PS_SKIP;
              end
            end else begin
              ps_nxt  = ps_p;
              acc_nxt = acc_p;
              if (!hdr_last) begin
                hpos_nxt = hpos_r + mav_pkg::HPOS_W'(1);
              end else if (sz_p == 32'd0) begin
                ctl.push           = 1'b1;
                ctl.burst.last_idx = mav_pkg::LAST_ONE;
                ctl.burst.status   = mav_pkg::ST_ZERO;
              end else begin
                ctl.push           = 1'b1;
                ctl.burst.w0       = mav_pkg::TAG_VIDEO;
                ctl.burst.w1       = sz_p;
                ctl.burst.last_idx = mav_pkg::LAST_CHUNK;
                left_nxt           = sz_p;
                if (nrec_r < mav_pkg::REC_W'(mav_pkg::MAX_INDEXED_FRAMES)) begin
                  mem_we           = 1'b1;
                  nrec_nxt         = nrec_r + mav_pkg::REC_W'(1);
                  ctl.burst.status = mav_pkg::ST_OK;
                end else begin
                  ctl.burst.status = mav_pkg::ST_FULL;
                end
              end
            end
          end
        end
      endcase
    end

    if (rd_wait_r == 2'd1) begin
      ctl.fill = size_ok_r;
      offs_nxt = offs_r + (size_ok_r ? rd_data : 32'd0) + 32'd8;
    end
  end

  assign mem_raddr = rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mav_pkg::PH_HEADER;
      ps_r       <= mav_pkg::PS_SKIP;
      hpos_r     <= '0;
      acc_r      <= 32'd0;
      left_r     <= 32'd0;
      nrec_r     <= '0;
      ptr_r      <= '0;
      offs_r     <= 32'd4;
      aud_pend_r <= 1'b1;
      rd_wait_r  <= 2'd0;
      size_ok_r  <= 1'b0;
      fcnt_r     <= 16'd0;
      aud_r      <= 32'd0;
    end else begin
      phase_r    <= phase_nxt;
      ps_r       <= ps_nxt;
      hpos_r     <= hpos_nxt;
      acc_r      <= acc_nxt;
      left_r     <= left_nxt;
      nrec_r     <= nrec_nxt;
      ptr_r      <= ptr_nxt;
      offs_r     <= offs_nxt;
      aud_pend_r <= aud_pend_nxt;
      rd_wait_r  <= rd_wait_nxt;
      size_ok_r  <= size_ok_nxt;
      if (cfg_we && cfg_index == mav_pkg::REG_FRAME_COUNT) begin
        fcnt_r <= cfg_wdata[15:0];
      end
      if (cfg_we && cfg_index == mav_pkg::REG_AUDIO_SIZE) begin
        aud_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
  end

endmodule

>>> hdl/mav_emit.sv
// Burst serializer: one pending slot and one active burst, one byte out per cycle on out_ready.
// Patches the stored frame size into index entries; depends on mav_pkg.
`timescale 1ns / 1ps
module mav_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  mav_pkg::ctl_t ctl,
  input  logic [31:0]   fill_data,
  output logic          pend_full,
  output logic          out_valid,
  input  logic          out_ready,
  output mav_pkg::out_t out_data
);

  mav_pkg::burst_t cur_r, cur_nxt;
  mav_pkg::burst_t pend_r, pend_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic            at_last;
  logic            cur_free;
  logic [31:0]     word;

  assign at_last  = (idx_r == cur_r.last_idx);
  assign cur_free = !cur_valid_r || (out_ready && at_last);

  always_comb begin
    cur_nxt        = cur_r;
    pend_nxt       = pend_r;
    cur_valid_nxt  = cur_valid_r;
    pend_valid_nxt = pend_valid_r;
    idx_nxt        = idx_r;
    if (cur_valid_r && out_ready && !at_last) begin
      idx_nxt = idx_r + 4'd1;
    end
    if (cur_free) begin
      idx_nxt = 4'd0;
      if (pend_valid_r) begin
        cur_nxt        = pend_r;
        cur_valid_nxt  = 1'b1;
        pend_valid_nxt = ctl.push;
        pend_nxt       = ctl.burst;
      end else begin
        cur_nxt       = ctl.burst;
        cur_valid_nxt = ctl.push;
      end
    end else if (ctl.push) begin
      pend_nxt       = ctl.burst;
      pend_valid_nxt = 1'b1;
    end
    if (ctl.fill) begin
      if (pend_valid_r && !cur_free) begin
        pend_nxt.w3 = fill_data;
      end else begin
        cur_nxt.w3 = fill_data;
      end
    end
  end

  always_comb begin
    case (idx_r[3:2])
      2'd0:    word = cur_r.w0;
      2'd1:    word = cur_r.w1;
      2'd2:    word = cur_r.w2;
      default: word = cur_r.w3;
    endcase
  end

  assign pend_full               = pend_valid_r;
  assign out_valid               = cur_valid_r;
  assign out_data.out_byte       = 8'(word >> {idx_r[1:0], 3'b000});
  assign out_data.last_in_run    = at_last;
  assign out_data.index_finished = cur_r.fin && at_last;
  assign out_data.status         = cur_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      idx_r        <= 4'd0;
    end else begin
      cur_valid_r  <= cur_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
  end

endmodule

>>> hdl/mav_chk.sv
// Port-level checker for mjpeg_to_avi_remuxer, attached by bind.
// Depends on mav_pkg and the top-level port list.
`timescale 1ns / 1ps
module mav_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [mav_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [mav_pkg::CFG_W-1:0]     cfg_wdata,
  input logic                          in_valid,
  input logic                          in_ready,
  input mav_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input mav_pkg::out_t                 out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_finished |-> out_data.last_in_run)
    else $error("index end not on last byte of a run");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  a_zero_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == mav_pkg::ST_ZERO |->
      out_data.out_byte == 8'd0 && out_data.last_in_run && !out_data.index_finished)
    else $error("stop result malformed");

endmodule

bind mjpeg_to_avi_remuxer mav_chk u_mav_chk (.*);
